>>> src/gnb_pkg.sv
// Shared types and constants of the Gaussian naive Bayes classifier.
// Used by gnb_class_cost, gnb_argmin and gaussian_naive_bayes_classify.
`default_nettype none

package gnb_pkg;

    localparam int FEAT_W       = 16;
    localparam int MAX_FEATURES = 4;
    localparam int MAX_CLASSES  = 3;
    localparam int WEIGHT_W     = 16;
    localparam int ABS_W        = 16;
    localparam int SQ_W         = 2 * ABS_W;
    localparam int PROD_W       = SQ_W + WEIGHT_W;
    localparam int TERM_SHIFT   = 16;
    localparam int TERM_W       = PROD_W - TERM_SHIFT;
    localparam int PSUM_W       = TERM_W + 1;
    localparam int OFFSET_W     = 21;
    localparam int COST_W       = 38;
    localparam int CLASS_W      = 2;
    localparam int IN_DATA_W    = FEAT_W * MAX_FEATURES;
    localparam int OUT_DATA_W   = 40;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int OFFSET_REG_W = OFFSET_W * MAX_CLASSES;
    localparam int PIPE_DEPTH   = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLASS0_MEAN   = 3'd0,
        REG_CLASS0_WEIGHT = 3'd1,
        REG_CLASS1_MEAN   = 3'd2,
        REG_CLASS1_WEIGHT = 3'd3,
        REG_CLASS2_MEAN   = 3'd4,
        REG_CLASS2_WEIGHT = 3'd5,
        REG_CLASS_OFFSET  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic diff;
        logic sq;
        logic wt;
        logic part;
        logic sum;
        logic pick;
    } stage_en_t;

endpackage

`default_nettype wire

>>> src/gaussian_naive_bayes_classify.sv
// Gaussian naive Bayes classifier: four Q8.8 features, up to three classes.
// Each item passes the difference, square, weight, partial-sum, total-cost and pick registers to m_tdata.
// Throughput: one item per cycle; each stage holds under back-pressure and
// drains into bubbles, so s_tready stays high while any stage is empty.
// Reset: synchronous active-low aresetn clears stage valid bits and all
// model registers to zero.
`default_nettype none

module gaussian_naive_bayes_classify #(
    parameter int FEATURE_COUNT = 4,
    parameter int CLASS_COUNT   = 3
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [gnb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gnb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // feature_a [15:0], feature_b [31:16], feature_c [47:32], feature_d [63:48]
    input  wire logic [gnb_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // predicted_class [1:0], best_cost [39:2]
    output logic      [gnb_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic [gnb_pkg::CFG_DATA_W-1:0]   mean_reg   [gnb_pkg::MAX_CLASSES];
    logic [gnb_pkg::CFG_DATA_W-1:0]   weight_reg [gnb_pkg::MAX_CLASSES];
    logic [gnb_pkg::OFFSET_REG_W-1:0] offset_reg;

    logic [gnb_pkg::PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [gnb_pkg::PIPE_DEPTH-1:0] stage_rdy;
    gnb_pkg::stage_en_t             stage_en;

    logic [gnb_pkg::MAX_CLASSES-1:0][gnb_pkg::COST_W-1:0] costs;
    logic [gnb_pkg::CLASS_W-1:0]                          class_idx;
    logic [gnb_pkg::COST_W-1:0]                           best_cost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < gnb_pkg::MAX_CLASSES; c++) begin
                mean_reg[c]   <= '0;
                weight_reg[c] <= '0;
            end
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gnb_pkg::REG_CLASS0_MEAN:   mean_reg[0]   <= cfg_wdata;
                gnb_pkg::REG_CLASS0_WEIGHT: weight_reg[0] <= cfg_wdata;
                gnb_pkg::REG_CLASS1_MEAN:   mean_reg[1]   <= cfg_wdata;
                gnb_pkg::REG_CLASS1_WEIGHT: weight_reg[1] <= cfg_wdata;
                gnb_pkg::REG_CLASS2_MEAN:   mean_reg[2]   <= cfg_wdata;
                gnb_pkg::REG_CLASS2_WEIGHT: weight_reg[2] <= cfg_wdata;
                gnb_pkg::REG_CLASS_OFFSET:
                    offset_reg <= cfg_wdata[gnb_pkg::OFFSET_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        stage_rdy[gnb_pkg::PIPE_DEPTH-1] = !valid_reg[gnb_pkg::PIPE_DEPTH-1] || m_tready;
        for (int k = gnb_pkg::PIPE_DEPTH-2; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next = valid_reg;
        if (stage_rdy[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < gnb_pkg::PIPE_DEPTH; k++) begin
            if (stage_rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
        stage_en.diff = stage_rdy[0];
        stage_en.sq   = stage_rdy[1];
        stage_en.wt   = stage_rdy[2];
        stage_en.part = stage_rdy[3];
        stage_en.sum  = stage_rdy[4];
        stage_en.pick = stage_rdy[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    genvar c;
    for (c = 0; c < gnb_pkg::MAX_CLASSES; c++) begin : g_class
        if (c < CLASS_COUNT) begin : g_on
            gnb_class_cost #(
                .FEATURE_COUNT (FEATURE_COUNT)
            ) u_cost (
                .aclk        (aclk),
                .stage_en    (stage_en),
                .features    (s_tdata),
                .mean_word   (mean_reg[c]),
                .weight_word (weight_reg[c]),
                .offset      (offset_reg[c*gnb_pkg::OFFSET_W +: gnb_pkg::OFFSET_W]),
                .cost        (costs[c])
            );
        end else begin : g_off
            assign costs[c] = '0;
        end
    end

    gnb_argmin #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_argmin (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .costs     (costs),
        .class_idx (class_idx),
        .best_cost (best_cost)
    );

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[gnb_pkg::PIPE_DEPTH-1];
    assign m_tdata  = {best_cost, class_idx};

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && valid_reg == '0)
        else $error("pipeline not empty after reset");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[gnb_pkg::CLASS_W-1:0] < gnb_pkg::CLASS_W'(CLASS_COUNT))
        else $error("predicted class out of range");

    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(valid_reg) == $countones($past(valid_reg))
            + ($past(s_tvalid && s_tready) ? 1 : 0)
            - ($past(m_tvalid && m_tready) ? 1 : 0))
        else $error("item lost or duplicated in pipeline");

    a_ready_when_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg != '1 |-> s_tready)
        else $error("input stalled while pipeline has a bubble");
`endif

endmodule

`default_nettype wire

>>> src/gnb_class_cost.sv
// Per-class cost pipeline: difference, square, weight, partial sums, total cost.
// Depends on gnb_pkg for widths and the stage enable struct.
`default_nettype none

module gnb_class_cost #(
    parameter int FEATURE_COUNT = 4
) (
    input  wire logic                                  aclk,
    input  wire gnb_pkg::stage_en_t                    stage_en,
    input  wire logic [gnb_pkg::IN_DATA_W-1:0]         features,
    input  wire logic [gnb_pkg::CFG_DATA_W-1:0]        mean_word,
    input  wire logic [gnb_pkg::CFG_DATA_W-1:0]        weight_word,
    input  wire logic [gnb_pkg::OFFSET_W-1:0]          offset,
    output logic      [gnb_pkg::COST_W-1:0]            cost
);

    logic [gnb_pkg::TERM_W-1:0] term_w [gnb_pkg::MAX_FEATURES];
    logic [gnb_pkg::PSUM_W-1:0] psum_lo_reg, psum_lo_next;
    logic [gnb_pkg::PSUM_W-1:0] psum_hi_reg, psum_hi_next;
    logic [gnb_pkg::COST_W-1:0] cost_reg, cost_next;

    genvar f;
    for (f = 0; f < gnb_pkg::MAX_FEATURES; f++) begin : g_feat
        if (f < FEATURE_COUNT) begin : g_on
            logic signed [gnb_pkg::FEAT_W:0]   diff;
            logic signed [gnb_pkg::FEAT_W:0]   diff_neg;
            logic        [gnb_pkg::ABS_W-1:0]  ad_reg, ad_next;
            logic        [gnb_pkg::SQ_W-1:0]   sq_reg, sq_next;
            logic        [gnb_pkg::PROD_W-1:0] prod;
            logic        [gnb_pkg::TERM_W-1:0] term_reg;

            always_comb begin
                diff = {features[f*gnb_pkg::FEAT_W + gnb_pkg::FEAT_W-1],
                        features[f*gnb_pkg::FEAT_W +: gnb_pkg::FEAT_W]}
                     - {mean_word[f*gnb_pkg::FEAT_W + gnb_pkg::FEAT_W-1],
                        mean_word[f*gnb_pkg::FEAT_W +: gnb_pkg::FEAT_W]};
                diff_neg = -diff;
                ad_next  = diff[gnb_pkg::FEAT_W] ? diff_neg[gnb_pkg::ABS_W-1:0]
                                                 : diff[gnb_pkg::ABS_W-1:0];
                sq_next  = {{gnb_pkg::ABS_W{1'b0}}, ad_reg}
                         * {{gnb_pkg::ABS_W{1'b0}}, ad_reg};
                prod     = {{gnb_pkg::WEIGHT_W{1'b0}}, sq_reg}
                         * {{gnb_pkg::SQ_W{1'b0}},
                            weight_word[f*gnb_pkg::WEIGHT_W +: gnb_pkg::WEIGHT_W]};
            end

            always_ff @(posedge aclk) begin
                if (stage_en.diff) begin
                    ad_reg <= ad_next;
                end
                if (stage_en.sq) begin
                    sq_reg <= sq_next;
                end
                if (stage_en.wt) begin
                    term_reg <= prod[gnb_pkg::PROD_W-1:gnb_pkg::TERM_SHIFT];
                end
            end

            assign term_w[f] = term_reg;
        end else begin : g_off
            assign term_w[f] = '0;
        end
    end

    always_comb begin
        psum_lo_next = {1'b0, term_w[0]} + {1'b0, term_w[1]};
        psum_hi_next = {1'b0, term_w[2]} + {1'b0, term_w[3]};
        cost_next    = {{(gnb_pkg::COST_W-gnb_pkg::OFFSET_W){offset[gnb_pkg::OFFSET_W-1]}},
                        offset}
                     + {{(gnb_pkg::COST_W-gnb_pkg::PSUM_W){1'b0}}, psum_lo_reg}
                     + {{(gnb_pkg::COST_W-gnb_pkg::PSUM_W){1'b0}}, psum_hi_reg};
    end

    always_ff @(posedge aclk) begin
        if (stage_en.part) begin
            psum_lo_reg <= psum_lo_next;
            psum_hi_reg <= psum_hi_next;
        end
        if (stage_en.sum) begin
            cost_reg <= cost_next;
        end
    end

    assign cost = cost_reg;

endmodule

`default_nettype wire

>>> src/gnb_argmin.sv
// Picks the class of least signed cost, ties to the lowest index, and registers it.
// Depends on gnb_pkg for widths and the stage enable struct.
`default_nettype none

module gnb_argmin #(
    parameter int CLASS_COUNT = 3
) (
    input  wire logic                                                 aclk,
    input  wire gnb_pkg::stage_en_t                                   stage_en,
    input  wire logic [gnb_pkg::MAX_CLASSES-1:0][gnb_pkg::COST_W-1:0] costs,
    output logic      [gnb_pkg::CLASS_W-1:0]                          class_idx,
    output logic      [gnb_pkg::COST_W-1:0]                           best_cost
);

    logic [gnb_pkg::CLASS_W-1:0] idx_reg, idx_next;
    logic [gnb_pkg::COST_W-1:0]  best_reg, best_next;

    always_comb begin
        best_next = costs[0];
        idx_next  = '0;
        for (int c = 1; c < gnb_pkg::MAX_CLASSES; c++) begin
            if (c < CLASS_COUNT && $signed(costs[c]) < $signed(best_next)) begin
                best_next = costs[c];
                idx_next  = gnb_pkg::CLASS_W'(c);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.pick) begin
            idx_reg  <= idx_next;
            best_reg <= best_next;
        end
    end

    assign class_idx = idx_reg;
    assign best_cost = best_reg;

endmodule

`default_nettype wire

>>> tb/sv/gaussian_naive_bayes_classify_tb.sv
// Self-checking bench for gaussian_naive_bayes_classify: streams feature vectors
// under random stalls across several loaded models and checks every class/cost item.
// Depends on gnb_pkg and the gaussian_naive_bayes_classify RTL only.
`timescale 1ns / 100ps

module gaussian_naive_bayes_classify_tb;

    localparam int N_FEATURES    = 4;
    localparam int N_CLASSES     = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = gnb_pkg::PIPE_DEPTH + 4;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 110;
    localparam int STALL_CYCLES  = 80;
    localparam int IDLE_PERCENT  = 7;
    localparam logic [gnb_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam longint COST_FLOOR = -64'sd1048576;
    localparam longint COST_CEIL  = 64'sd137438953471;

    typedef struct packed {
        logic [gnb_pkg::CLASS_W-1:0] cls;
        logic [gnb_pkg::COST_W-1:0]  cost;
    } verdict_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [gnb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gnb_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [gnb_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [gnb_pkg::OUT_DATA_W-1:0]  m_tdata;

    logic [gnb_pkg::CFG_DATA_W-1:0]   class_mean   [N_CLASSES] = '{default: '0};
    logic [gnb_pkg::CFG_DATA_W-1:0]   class_weight [N_CLASSES] = '{default: '0};
    logic [gnb_pkg::OFFSET_REG_W-1:0] class_offset = '0;

    logic [gnb_pkg::IN_DATA_W-1:0] feature_queue [$];
    verdict_t                      verdict_queue [$];

    bit  took_item     = 1'b0;
    bit  calm_phase    = 1'b0;
    bit  stall_request = 1'b0;
    int  stall_left    = 0;
    int  cycle_count   = 0;
    int  error_count   = 0;
    int  vectors_in    = 0;
    int  results_out   = 0;
    int  model_loads   = 0;
    int  class_wins [4] = '{default: 0};

    gaussian_naive_bayes_classify #(
        .FEATURE_COUNT (N_FEATURES),
        .CLASS_COUNT   (N_CLASSES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void add_feature(logic [gnb_pkg::IN_DATA_W-1:0] item);
        feature_queue.insert(feature_queue.size(), item);
    endfunction

    function automatic void add_verdict(verdict_t item);
        verdict_queue.insert(verdict_queue.size(), item);
    endfunction

    function automatic verdict_t predict_verdict(logic [gnb_pkg::IN_DATA_W-1:0] feats);
        longint          x, mean, d, cost, best;
        longint unsigned ad, w, term;
        int              c, f, best_idx;
        verdict_t        v;
        best = 0;
        best_idx = 0;
        for (c = 0; c < N_CLASSES; c++) begin
            cost = longint'($signed(class_offset[gnb_pkg::OFFSET_W*c +: gnb_pkg::OFFSET_W]));
            for (f = 0; f < N_FEATURES; f++) begin
                x    = longint'($signed(feats[gnb_pkg::FEAT_W*f +: gnb_pkg::FEAT_W]));
                mean = longint'($signed(class_mean[c][gnb_pkg::FEAT_W*f +: gnb_pkg::FEAT_W]));
                w    = class_weight[c][gnb_pkg::WEIGHT_W*f +: gnb_pkg::WEIGHT_W];
                d    = x - mean;
                ad   = (d < 0) ? -d : d;
                term = (ad * ad * w) >> gnb_pkg::TERM_SHIFT;
                cost += longint'(term);
            end
            if (cost < COST_FLOOR) cost = COST_FLOOR;
            if (cost > COST_CEIL) cost = COST_CEIL;
            if (c == 0 || cost < best) begin
                best = cost;
                best_idx = c;
            end
        end
        v.cls  = best_idx[gnb_pkg::CLASS_W-1:0];
        v.cost = best[gnb_pkg::COST_W-1:0];
        return v;
    endfunction

    function automatic logic [gnb_pkg::IN_DATA_W-1:0] near_class_item(int c, int spread);
        logic [gnb_pkg::IN_DATA_W-1:0] word;
        int                            f, v;
        for (f = 0; f < N_FEATURES; f++) begin
            v = int'($signed(class_mean[c][gnb_pkg::FEAT_W*f +: gnb_pkg::FEAT_W]))
                + int'($urandom_range(2 * spread)) - spread;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            word[gnb_pkg::FEAT_W*f +: gnb_pkg::FEAT_W] = v[gnb_pkg::FEAT_W-1:0];
        end
        return word;
    endfunction

    function automatic logic [gnb_pkg::CFG_DATA_W-1:0] random_mean_word(int span);
        logic [gnb_pkg::CFG_DATA_W-1:0] word;
        int                             f, v;
        for (f = 0; f < N_FEATURES; f++) begin
            v = int'($urandom_range(2 * span)) - span;
            word[gnb_pkg::FEAT_W*f +: gnb_pkg::FEAT_W] = v[gnb_pkg::FEAT_W-1:0];
        end
        return word;
    endfunction

    function automatic logic [gnb_pkg::CFG_DATA_W-1:0] random_weight_word(int top);
        logic [gnb_pkg::CFG_DATA_W-1:0] word;
        int                             f;
        for (f = 0; f < N_FEATURES; f++)
            word[gnb_pkg::WEIGHT_W*f +: gnb_pkg::WEIGHT_W] =
                gnb_pkg::WEIGHT_W'($urandom_range(top));
        return word;
    endfunction

    task automatic write_reg(logic [gnb_pkg::CFG_INDEX_W-1:0] idx,
                             logic [gnb_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            gnb_pkg::REG_CLASS0_MEAN:   class_mean[0]   = data;
            gnb_pkg::REG_CLASS0_WEIGHT: class_weight[0] = data;
            gnb_pkg::REG_CLASS1_MEAN:   class_mean[1]   = data;
            gnb_pkg::REG_CLASS1_WEIGHT: class_weight[1] = data;
            gnb_pkg::REG_CLASS2_MEAN:   class_mean[2]   = data;
            gnb_pkg::REG_CLASS2_WEIGHT: class_weight[2] = data;
            gnb_pkg::REG_CLASS_OFFSET:  class_offset    = data[gnb_pkg::OFFSET_REG_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (feature_queue.size() != 0 || verdict_queue.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_random_items(int count);
        int i, spread;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(2))
                0:       spread = 256;
                1:       spread = 2048;
                default: spread = 12000;
            endcase
            if ($urandom_range(99) < 80)
                add_feature(near_class_item($urandom_range(N_CLASSES - 1), spread));
            else
                add_feature({$urandom, $urandom});
        end
    endtask

    // sender: take accepted items, predict their verdicts
    always @(posedge aclk) begin
        took_item = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            add_verdict(predict_verdict(feature_queue.pop_front()));
            took_item = 1'b1;
            vectors_in++;
        end
    end

    // hold an offered item until taken, otherwise offer the next or idle
    always @(negedge aclk) begin
        if (!s_tvalid || took_item) begin
            if (feature_queue.size() != 0
                    && (calm_phase || $urandom_range(99) >= IDLE_PERCENT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= feature_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_phase || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_out++;
            class_wins[m_tdata[gnb_pkg::CLASS_W-1:0]]++;
            if (verdict_queue.size() == 0) begin
                $error("unexpected item: predicted_class %0d best_cost %0d",
                       m_tdata[gnb_pkg::CLASS_W-1:0],
                       $signed(m_tdata[gnb_pkg::CLASS_W +: gnb_pkg::COST_W]));
                error_count++;
            end else begin
                want = verdict_queue.pop_front();
                if (m_tdata[gnb_pkg::CLASS_W-1:0] !== want.cls) begin
                    $error("predicted_class: expected %0d, got %0d",
                           want.cls, m_tdata[gnb_pkg::CLASS_W-1:0]);
                    error_count++;
                end
                if (m_tdata[gnb_pkg::CLASS_W +: gnb_pkg::COST_W] !== want.cost) begin
                    $error("best_cost: expected %0d, got %0d",
                           $signed(want.cost),
                           $signed(m_tdata[gnb_pkg::CLASS_W +: gnb_pkg::COST_W]));
                    error_count++;
                end
            end
        end
    end

    initial begin
        int                             p, weight_top;
        logic [gnb_pkg::CFG_DATA_W-1:0] tie_mean, tie_weight;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all-zero model after reset: every class ties at zero cost
        add_feature('0);
        add_feature({N_FEATURES{16'h7FFF}});
        add_feature({N_FEATURES{16'h8000}});
        drain();

        // extreme means, weights and offsets; sign bit of offset word and
        // unused index must be dropped
        write_reg(gnb_pkg::REG_CLASS0_MEAN,   {N_FEATURES{16'h8000}});
        write_reg(gnb_pkg::REG_CLASS0_WEIGHT, {N_FEATURES{16'hFFFF}});
        write_reg(gnb_pkg::REG_CLASS1_MEAN,   {N_FEATURES{16'h7FFF}});
        write_reg(gnb_pkg::REG_CLASS1_WEIGHT, {N_FEATURES{16'hFFFF}});
        write_reg(gnb_pkg::REG_CLASS2_MEAN,   '0);
        write_reg(gnb_pkg::REG_CLASS2_WEIGHT, {N_FEATURES{16'h0001}});
        write_reg(gnb_pkg::REG_CLASS_OFFSET,
                  {1'b1, 21'h000000, 21'h0FFFFF, 21'h100000});
        write_reg(CFG_UNUSED_INDEX, '1);
        model_loads++;
        add_feature({N_FEATURES{16'h7FFF}});
        add_feature({N_FEATURES{16'h8000}});
        add_feature('0);
        add_feature({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        add_feature({16'hFF00, 16'h0100, 16'hFFFF, 16'h0001});
        add_feature({16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000});
        drain();

        // identical classes tie to class 0, then classes 1 and 2 tie below class 0
        tie_mean   = {16'h0000, 16'h0040, 16'hFF00, 16'h0100};
        tie_weight = {16'h0800, 16'h1000, 16'h0400, 16'h2000};
        write_reg(gnb_pkg::REG_CLASS0_MEAN,   tie_mean);
        write_reg(gnb_pkg::REG_CLASS0_WEIGHT, tie_weight);
        write_reg(gnb_pkg::REG_CLASS1_MEAN,   tie_mean);
        write_reg(gnb_pkg::REG_CLASS1_WEIGHT, tie_weight);
        write_reg(gnb_pkg::REG_CLASS2_MEAN,   tie_mean);
        write_reg(gnb_pkg::REG_CLASS2_WEIGHT, tie_weight);
        write_reg(gnb_pkg::REG_CLASS_OFFSET,  {21'd7, 21'd7, 21'd7});
        model_loads++;
        add_feature(tie_mean);
        add_feature('0);
        add_feature({N_FEATURES{16'h7FFF}});
        add_feature({N_FEATURES{16'h8000}});
        drain();
        write_reg(gnb_pkg::REG_CLASS_OFFSET, {21'd5, 21'd5, 21'd9});
        model_loads++;
        add_feature(tie_mean);
        add_feature({16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0});
        add_feature({N_FEATURES{16'h8000}});
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            weight_top = (p % 2) ? 65535 : 2048;
            write_reg(gnb_pkg::REG_CLASS0_MEAN,
                      (p == 4) ? {$urandom, $urandom} : random_mean_word(4096));
            write_reg(gnb_pkg::REG_CLASS1_MEAN,
                      (p == 4) ? {$urandom, $urandom} : random_mean_word(4096));
            write_reg(gnb_pkg::REG_CLASS2_MEAN,
                      (p == 4) ? {$urandom, $urandom} : random_mean_word(4096));
            write_reg(gnb_pkg::REG_CLASS0_WEIGHT,
                      (p == 3) ? {N_FEATURES{16'hFFFF}} : random_weight_word(weight_top));
            write_reg(gnb_pkg::REG_CLASS1_WEIGHT,
                      (p == 3) ? {N_FEATURES{16'hFFFF}} : random_weight_word(weight_top));
            write_reg(gnb_pkg::REG_CLASS2_WEIGHT,
                      (p == 3) ? {N_FEATURES{16'hFFFF}} : random_weight_word(weight_top));
            write_reg(gnb_pkg::REG_CLASS_OFFSET, {$urandom, $urandom});
            model_loads++;
            calm_phase = (p == 1);
            if (p == 2)
                stall_request = 1'b1;
            queue_random_items(PHASE_ITEMS / 2);
            if (p == 3)
                drain();
            queue_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end
        calm_phase = 1'b0;

        $display("%0d feature vectors in, %0d verdicts out, %0d models loaded",
                 vectors_in, results_out, model_loads);
        $display("wins by class: %0d / %0d / %0d",
                 class_wins[0], class_wins[1], class_wins[2]);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
